>>> src/fgw_pkg.sv
// Shared types and constants of the functional graph walk block.
package fgw_pkg;

    localparam int CH_W        = 11;
    localparam int HOP_W       = 10;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 16;

    localparam logic [HOP_W-1:0] HOP_MAX = '1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_WALK = 1'b1;

    typedef struct packed {
        logic clr;
        logic accept;
        logic ld_chk;
        logic wk_step;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_mode;
        logic start_ok;
        logic next_zero;
        logic at_limit;
        logic out_free;
    } t_status;

endpackage

>>> src/fgw_ram.sv
// Generic single write port RAM with one registered read port.
module fgw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/fgw_datapath.sv
// Datapath: successor table, walk step counter, result and output registers.
module fgw_datapath #(
    parameter int CHANNELS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fgw_pkg::t_cmd                   i_cmd,
    output fgw_pkg::t_status                o_st,
    input  logic                            i_in_mode,
    input  logic [fgw_pkg::S_TDATA_W-1:0]   i_in_tdata,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fgw_pkg::HOP_W-1:0]       o_out_hop,
    output logic                            o_out_loops
);

    localparam int AW = $clog2(CHANNELS + 1);
    localparam int CW = $clog2(CHANNELS);

    logic [fgw_pkg::CH_W-1:0] in_src;
    logic [fgw_pkg::CH_W-1:0] in_tgt;
    logic [fgw_pkg::CH_W-1:0] in_start;
    logic                     src_ok;
    logic                     tgt_ok;
    logic                     start_ok;

    logic [AW-1:0]            r_clr_addr;
    logic [AW-1:0]            n_clr_addr;
    logic [AW-1:0]            r_src;
    logic [fgw_pkg::CH_W-1:0] r_tgt;
    logic                     r_ld_ok;
    logic [CW-1:0]            r_steps;
    logic [fgw_pkg::HOP_W-1:0] r_res_hop;
    logic                     r_res_loops;
    logic                     r_out_valid;
    logic [fgw_pkg::HOP_W-1:0] r_out_hop;
    logic                     r_out_loops;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [fgw_pkg::CH_W-1:0] ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [fgw_pkg::CH_W-1:0] ram_rdata;

    logic                     next_zero;
    logic                     at_limit;
    logic                     advance;
    logic [fgw_pkg::HOP_W-1:0] sat_hop;

    assign in_src   = i_in_tdata[fgw_pkg::CH_W-1:0];
    assign in_tgt   = i_in_tdata[2*fgw_pkg::CH_W-1:fgw_pkg::CH_W];
    assign in_start = i_in_tdata[3*fgw_pkg::CH_W-1:2*fgw_pkg::CH_W];

    assign src_ok   = (in_src != '0) && (32'(in_src) <= 32'(CHANNELS));
    assign tgt_ok   = 32'(in_tgt) <= 32'(CHANNELS);
    assign start_ok = (in_start != '0) && (32'(in_start) <= 32'(CHANNELS));

    assign next_zero = (ram_rdata == '0);
    assign at_limit  = (r_steps == CW'(CHANNELS - 1));
    assign advance   = i_cmd.wk_step && !next_zero && !at_limit;
    assign sat_hop   = (32'(r_steps) >= 32'(fgw_pkg::HOP_MAX)) ?
                       fgw_pkg::HOP_MAX : fgw_pkg::HOP_W'(r_steps);

    assign n_clr_addr = r_clr_addr + AW'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_src;
        ram_wdata = r_tgt;
        if (i_cmd.clr) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (i_cmd.ld_chk && r_ld_ok && next_zero) begin
            ram_we    = 1'b1;
        end
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = AW'(in_src);
        if (i_cmd.accept) begin
            if (i_in_mode == fgw_pkg::MODE_WALK) begin
                ram_re    = start_ok;
                ram_raddr = AW'(in_start);
            end else begin
                ram_re    = src_ok;
            end
        end else if (advance) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(ram_rdata);
        end
    end

    fgw_ram #(
        .WIDTH (fgw_pkg::CH_W),
        .DEPTH (CHANNELS + 1)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= n_clr_addr;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_src       <= AW'(in_src);
            r_tgt       <= in_tgt;
            r_ld_ok     <= src_ok && tgt_ok;
            r_steps     <= '0;
            r_res_hop   <= '0;
            r_res_loops <= 1'b0;
        end else if (i_cmd.wk_step) begin
            if (next_zero) begin
                r_res_hop   <= sat_hop;
                r_res_loops <= 1'b0;
            end else if (at_limit) begin
                r_res_hop   <= '0;
                r_res_loops <= 1'b1;
            end else begin
                r_steps <= r_steps + CW'(1);
            end
        end
        if (i_cmd.push) begin
            r_out_hop   <= r_res_hop;
            r_out_loops <= r_res_loops;
        end
    end

    assign o_st.clr_last  = (r_clr_addr == AW'(CHANNELS));
    assign o_st.in_mode   = i_in_mode;
    assign o_st.start_ok  = start_ok;
    assign o_st.next_zero = next_zero;
    assign o_st.at_limit  = at_limit;
    assign o_st.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_hop   = r_out_hop;
    assign o_out_loops = r_out_loops;

`ifndef NO_ASSERTIONS
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_steps == $past(r_steps) + CW'(1))
        else $error("walk step counter did not advance by one hop");

    a_loop_zero_hops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_loops && r_out_hop != '0))
        else $error("loop result carries a nonzero hop count");
`endif

endmodule

>>> src/fgw_ctrl.sv
// Controller state machine: table clearing, load check and walk sequencing.
module fgw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  fgw_pkg::t_status i_st,
    output fgw_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_CHK,
        S_WK_STEP,
        S_WK_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.in_mode == fgw_pkg::MODE_LOAD) begin
                        n_state = S_LD_CHK;
                    end else if (i_st.start_ok) begin
                        n_state = S_WK_STEP;
                    end else begin
                        n_state = S_WK_DONE;
                    end
                end
            end
            S_LD_CHK: begin
                o_cmd.ld_chk = 1'b1;
                n_state      = S_IDLE;
            end
            S_WK_STEP: begin
                o_cmd.wk_step = 1'b1;
                if (i_st.next_zero || i_st.at_limit) begin
                    n_state = S_WK_DONE;
                end
            end
            S_WK_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> r_state == S_IDLE)
        else $error("input ready outside of idle state");

    a_walk_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WK_STEP |-> $past(r_state) == S_WK_STEP || $past(r_state) == S_IDLE)
        else $error("walk entered from an unexpected state");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_st.out_free)
        else $error("result pushed into an occupied output register");
`endif

endmodule

>>> src/functional_graph_walk_cycle_detect.sv
// Top level of the successor table walk block with loop detection.
//
// Input channel s_axis: one transaction is either a load (tuser = 0) that
// sets the successor of a channel if that entry is still empty, or a walk
// (tuser = 1) that follows successors from a start channel.
// Output channel m_axis: one transaction per walk, carrying the hop count
// and a loop flag in tuser. Loads produce no output.
// After reset the successor table is swept to zero, one entry per cycle,
// all CHANNELS + 1 entries; s_axis_tready stays low until it ends.
// A load reads the table entry, then does a conditional write through the
// single write port if that entry is still empty. A walk reads the start
// entry when it is accepted, then takes one table read per hop until it
// reaches an empty successor, and then moves the result into the output register.
// A walk that loops reads CHANNELS entries,
// since a loop is recognized when CHANNELS - 1 hops have been taken and the
// entry reached still has a successor.
// The result waits in an output register; loads are still accepted while it
// waits, and a following walk holds at its end until that register drains.
// Only one item is worked on at a time.
module functional_graph_walk_cycle_detect #(
    parameter int CHANNELS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // source_channel [10:0], target_channel [21:11], start_channel [32:22]
    input  logic [fgw_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // mode
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hop_count [9:0]
    output logic [fgw_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // loops
    output logic                          m_axis_tuser
);

    fgw_pkg::t_cmd             cmd;
    fgw_pkg::t_status          st;
    logic [fgw_pkg::HOP_W-1:0] out_hop;

    fgw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    fgw_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_in_mode   (s_axis_tuser),
        .i_in_tdata  (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_hop   (out_hop),
        .o_out_loops (m_axis_tuser)
    );

    assign m_axis_tdata = {{(fgw_pkg::M_TDATA_W - fgw_pkg::HOP_W){1'b0}}, out_hop};

endmodule

>>> test/fgw_walk_checker.sv
// Checker for the successor table walk block: predicts each walk result and compares it.
module fgw_walk_checker #(
    parameter int CHANNELS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [fgw_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [fgw_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          m_axis_tuser,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [fgw_pkg::HOP_W-1:0] hop_count;
        logic                      loops;
    } t_walk_result;

    logic [fgw_pkg::CH_W-1:0] succ_tbl [0:CHANNELS];
    bit                       seen     [0:CHANNELS];
    t_walk_result             walks_in_flight [$];
    int                       mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic t_walk_result chase_successors(input logic [fgw_pkg::CH_W-1:0] start);
        t_walk_result r;
        int cur;
        int nxt;
        r = '0;
        for (int c = 0; c <= CHANNELS; c++) seen[c] = 1'b0;
        cur = (start >= 1 && start <= CHANNELS) ? int'(start) : 0;
        while (cur != 0) begin
            seen[cur] = 1'b1;
            nxt = int'(succ_tbl[cur]);
            if (nxt == 0) break;
            if (seen[nxt]) begin
                r.loops = 1'b1;
                break;
            end
            cur = nxt;
            if (r.hop_count != fgw_pkg::HOP_MAX) r.hop_count = r.hop_count + 1'b1;
        end
        if (r.loops) r.hop_count = '0;
        return r;
    endfunction

    // A result transaction is checked before the input transaction of the same edge,
    // since a walk accepted at this edge cannot have finished yet.
    always @(posedge i_clk) begin : monitor
        logic [fgw_pkg::CH_W-1:0] src;
        logic [fgw_pkg::CH_W-1:0] dst;
        logic [fgw_pkg::CH_W-1:0] start;
        t_walk_result             want;
        if (!i_rst_n) begin
            for (int c = 0; c <= CHANNELS; c++) succ_tbl[c] = '0;
            walks_in_flight.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (walks_in_flight.size() == 0) begin
                    report_mismatch($sformatf("result hop_count %0d loops %0b with no walk pending",
                                              m_axis_tdata[fgw_pkg::HOP_W-1:0], m_axis_tuser));
                end else begin
                    want = walks_in_flight.pop_front();
                    if (m_axis_tdata[fgw_pkg::HOP_W-1:0] !== want.hop_count)
                        report_mismatch($sformatf("hop_count %0d, predicted %0d",
                                                  m_axis_tdata[fgw_pkg::HOP_W-1:0],
                                                  want.hop_count));
                    if (m_axis_tuser !== want.loops)
                        report_mismatch($sformatf("loops %0b, predicted %0b",
                                                  m_axis_tuser, want.loops));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                src   = s_axis_tdata[fgw_pkg::CH_W-1:0];
                dst   = s_axis_tdata[2*fgw_pkg::CH_W-1:fgw_pkg::CH_W];
                start = s_axis_tdata[3*fgw_pkg::CH_W-1:2*fgw_pkg::CH_W];
                if (s_axis_tuser == fgw_pkg::MODE_LOAD) begin
                    if (src >= 1 && src <= CHANNELS && dst <= CHANNELS && succ_tbl[src] == '0)
                        succ_tbl[src] = dst;
                end else begin
                    walks_in_flight.push_back(chase_successors(start));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= walks_in_flight.size();
    end

endmodule

>>> test/functional_graph_walk_cycle_detect_tb.sv
// Testbench top: drives loads and walks into the successor table walk block and gives the verdict.
module functional_graph_walk_cycle_detect_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS     = 1024;
    localparam int WANTED_ITEMS = 1450;
    localparam int CALM_ITEMS   = 150;
    localparam int LONG_CHAIN   = 520;
    localparam int DRAIN_CYCLES = CHANNELS + 64;
    localparam int CYCLE_LIMIT  = 6_000_000;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [fgw_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b1;
    logic [fgw_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                            m_axis_tuser;
    int                              fail_count;
    int                              pending;

    int          items_done  = 0;
    bit          calm        = 1'b0;
    bit          tx_choppy   = 1'b1;
    bit          rx_choppy   = 1'b1;
    int          rx_wait     = 0;
    int unsigned cycle_count = 0;
    bit          occupied [0:CHANNELS];
    int          fresh_pool [$];

    always #2 i_clk = ~i_clk;

    functional_graph_walk_cycle_detect #(
        .CHANNELS(CHANNELS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fgw_walk_checker #(
        .CHANNELS(CHANNELS)
    ) u_walk_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) rx_choppy <= ~rx_choppy;
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
        end else if (rx_choppy && $urandom_range(0, 5) == 0) begin
            rx_wait       <= $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic shuffle(ref int q[$]);
        int j;
        int t;
        for (int i = q.size() - 1; i > 0; i--) begin
            j    = $urandom_range(0, i);
            t    = q[i];
            q[i] = q[j];
            q[j] = t;
        end
    endtask

    function automatic int take_fresh();
        int c;
        while (fresh_pool.size() > 0) begin
            c = fresh_pool.pop_front();
            if (!occupied[c]) return c;
        end
        return 0;
    endfunction

    task automatic send_item(input logic mode, input int src, input int dst, input int start);
        if (!calm && tx_choppy && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(fgw_pkg::S_TDATA_W - 3*fgw_pkg::CH_W){1'b0}},
                          start[fgw_pkg::CH_W-1:0], dst[fgw_pkg::CH_W-1:0],
                          src[fgw_pkg::CH_W-1:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        if (mode == fgw_pkg::MODE_WALK) begin
            items_done++;
        end else if (src >= 1 && src <= CHANNELS && dst != 0 && dst <= CHANNELS
                     && !occupied[src]) begin
            occupied[src] = 1'b1;
            items_done++;
        end
        if ($urandom_range(0, 199) == 0) tx_choppy = ~tx_choppy;
        if (items_done >= WANTED_ITEMS - CALM_ITEMS) calm = 1'b1;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // The chain ends open, closes onto one of its own channels, or joins any channel.
    task automatic build_chain(input int n, input int end_kind);
        int node [$];
        int ord [$];
        int c;
        int dst;
        repeat (n) begin
            c = take_fresh();
            if (c != 0) node.push_back(c);
        end
        if (node.size() == 0) return;
        for (int i = 0; i < node.size() - 1; i++) ord.push_back(i);
        if (end_kind != 0) ord.push_back(node.size() - 1);
        shuffle(ord);
        foreach (ord[k]) begin
            if (ord[k] < node.size() - 1) dst = node[ord[k] + 1];
            else if (end_kind == 1) dst = node[$urandom_range(0, node.size() - 1)];
            else dst = $urandom_range(1, CHANNELS);
            send_item(fgw_pkg::MODE_LOAD, node[ord[k]], dst, $urandom_range(0, 2047));
            if ($urandom_range(0, 7) == 0)
                send_item(fgw_pkg::MODE_WALK, $urandom_range(0, 2047), $urandom_range(0, 2047),
                          node[$urandom_range(0, node.size() - 1)]);
        end
        send_item(fgw_pkg::MODE_WALK, $urandom_range(0, 2047), $urandom_range(0, 2047),
                  node[0]);
        repeat ($urandom_range(0, 2))
            send_item(fgw_pkg::MODE_WALK, $urandom_range(0, 2047), $urandom_range(0, 2047),
                      node[$urandom_range(0, node.size() - 1)]);
    endtask

    initial begin
        int a;
        int b;
        for (int ch = 1; ch <= CHANNELS; ch++) fresh_pool.push_back(ch);
        shuffle(fresh_pool);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(fgw_pkg::MODE_LOAD, 1, 2, 2047);
        send_item(fgw_pkg::MODE_LOAD, 2, 3, 0);
        send_item(fgw_pkg::MODE_WALK, 0, 0, 1);
        send_item(fgw_pkg::MODE_LOAD, 1, 5, 0);
        send_item(fgw_pkg::MODE_WALK, 2047, 2047, 1);
        send_item(fgw_pkg::MODE_LOAD, 0, 7, 0);
        send_item(fgw_pkg::MODE_LOAD, 1025, 4, 0);
        send_item(fgw_pkg::MODE_LOAD, 2047, 2047, 2047);
        send_item(fgw_pkg::MODE_LOAD, 3, 1025, 0);
        send_item(fgw_pkg::MODE_LOAD, 3, 0, 0);
        send_item(fgw_pkg::MODE_WALK, 0, 0, 3);
        send_item(fgw_pkg::MODE_LOAD, 3, 1, 0);
        send_item(fgw_pkg::MODE_WALK, 0, 0, 2);
        send_item(fgw_pkg::MODE_LOAD, 1024, 1024, 0);
        send_item(fgw_pkg::MODE_WALK, 0, 0, 1024);
        send_item(fgw_pkg::MODE_WALK, 0, 0, 0);
        send_item(fgw_pkg::MODE_WALK, 0, 0, 1025);
        send_item(fgw_pkg::MODE_WALK, 2047, 2047, 2047);
        send_item(fgw_pkg::MODE_WALK, 0, 0, 500);
        send_item(fgw_pkg::MODE_LOAD, 1000, 1024, 0);
        send_item(fgw_pkg::MODE_WALK, 0, 0, 1000);
        send_item(fgw_pkg::MODE_LOAD, 4, 1, 0);
        send_item(fgw_pkg::MODE_WALK, 0, 0, 4);
        wait_drained();

        build_chain(LONG_CHAIN, 0);
        while (items_done < WANTED_ITEMS) begin
            if (!calm && $urandom_range(0, 39) == 0) wait_drained();
            if ($urandom_range(0, 9) < 7 && fresh_pool.size() > 0) begin
                build_chain($urandom_range(1, 12), $urandom_range(0, 2));
            end else begin
                a = ($urandom_range(0, 3) != 0) ? $urandom_range(1, CHANNELS)
                                                : $urandom_range(0, 2047);
                b = ($urandom_range(0, 4) != 0) ? $urandom_range(0, CHANNELS)
                                                : $urandom_range(0, 2047);
                if ($urandom_range(0, 1) == 0)
                    send_item(fgw_pkg::MODE_LOAD, a, b, $urandom_range(0, 2047));
                else
                    send_item(fgw_pkg::MODE_WALK, $urandom_range(0, 2047), b, a);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
